// ----- rtl/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Code 128 set B decoder package
// Shared types, symbol table and codes for the module-stream decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int SYM_COUNT   = 106;
   localparam int SYM_MODULES = 11;

   typedef logic [1:0]  code_set_type;
   typedef logic [10:0] sym_pat_type;
   typedef logic [23:0] sym_runs_type;   // six run widths, one per nibble
   typedef logic [6:0]  sym_value_type;

   localparam code_set_type  CODE_SET_B    = 2'd1;
   localparam sym_value_type START_B_VALUE = 7'd104;
   localparam logic [7:0]    ASCII_OFFSET  = 8'd32;
   localparam sym_runs_type  STOP_HEAD_RUNS = 24'h233111;

   // Run widths of every symbol value, first bar in the highest nibble
   localparam sym_runs_type SYM_RUNS [SYM_COUNT] = '{
      24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
      24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
      24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
      24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
      24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
      24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
      24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
      24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
      24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
      24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
      24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
      24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
      24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
      24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
      24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
      24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
      24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
      24'h411131, 24'h211412, 24'h211214, 24'h211232
   };

   typedef enum logic [1:0] {
      PH_START,
      PH_DATA,
      PH_TAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_CHECK   = 3'd1,
      ST_BADSET  = 3'd2,
      ST_NOSTART = 3'd3,
      ST_BADPAT  = 3'd4,
      ST_EMPTY   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      EV_DATA,
      EV_FINISH,
      EV_ERROR
   } ev_kind_type;

   typedef struct packed {
      logic func;
      logic module_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      status_type status;
      logic       last;
   } rsp_type;

   // Classified event passed from the collector to the result stage
   typedef struct packed {
      ev_kind_type   kind;
      sym_value_type value;
      status_type    status;
   } ev_type;

   // Expand run widths into the 11-module bar-first level pattern
   function automatic sym_pat_type expand_runs(input sym_runs_type runs);
      sym_pat_type pat;
      logic        level;
      logic [3:0]  width;
      pat   = '0;
      level = 1'b1;
      for (int k = 0; k < 6; k++) begin
         width = runs[(5 - k) * 4 +: 4];
         for (int j = 0; j < 4; j++) begin
            if (4'(j) < width) begin
               pat = {pat[9:0], level};
            end
         end
         level = ~level;
      end
      return pat;
   endfunction

endpackage

// ----- rtl/cbd_queue.sv -----
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer of DEPTH words (DEPTH of two or more).
// ----------------------------------------------------------------------------
module cbd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/cbd_front.sv -----
// ----------------------------------------------------------------------------
// Module collector and symbol classifier
// Gathers module bits into symbols, matches them and tracks the scan phase.
// ----------------------------------------------------------------------------
module cbd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  cbd_pkg::req_type      req_word,
   input  cbd_pkg::code_set_type code_set,
   input  logic                  ev_full,
   output logic                  ev_push,
   output cbd_pkg::ev_type       ev_word
);

   import cbd_pkg::*;

   phase_type     phase_ff, phase_in;
   sym_pat_type   window_ff, window_in;
   logic [3:0]    count_ff, count_in;

   logic          accept;
   sym_pat_type   win_shift, canon;
   logic [3:0]    cnt_inc;
   logic          sym_done, tail_done, tail_ok, set_bad;
   logic          match, is_stop, is_start_b;
   sym_value_type match_idx;

   assign accept    = req_push && !ev_full;
   assign win_shift = {window_ff[9:0], req_word.module_bit};
   assign cnt_inc   = count_ff + 4'd1;
   assign sym_done  = (cnt_inc == 4'(SYM_MODULES));
   assign tail_done = (cnt_inc == 4'd2);
   assign tail_ok   = (win_shift == 11'd0) || (win_shift == 11'd3);
   assign set_bad   = (code_set != CODE_SET_B);

   // Table patterns all open with a bar; flip a space-first window
   assign canon = win_shift[10] ? win_shift : ~win_shift;

   always_comb begin
      match     = 1'b0;
      match_idx = '0;
      for (int i = 0; i < SYM_COUNT; i++) begin
         if (canon == expand_runs(SYM_RUNS[i])) begin
            match     = 1'b1;
            match_idx = match_idx | sym_value_type'(i);
         end
      end
   end

   assign is_stop    = (canon == expand_runs(STOP_HEAD_RUNS));
   assign is_start_b = match && (match_idx == START_B_VALUE);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_word.func) begin
            phase_in = PH_START;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if ((count_ff == 4'd0) && set_bad) begin
                     phase_in = PH_DONE;
                  end else if (sym_done) begin
                     phase_in = is_start_b ? PH_DATA : PH_DONE;
                  end
               end
               PH_DATA: begin
                  if (sym_done) begin
                     phase_in = is_stop ? PH_TAIL : (match ? PH_DATA : PH_DONE);
                  end
               end
               PH_TAIL: begin
                  if (tail_done) begin
                     phase_in = PH_DONE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Window, count and event
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      ev_push   = 1'b0;
      ev_word   = '{kind: EV_ERROR, value: '0, status: ST_BADPAT};
      if (accept) begin
         if (req_word.func) begin
            window_in = '0;
            count_in  = '0;
            case (phase_ff)
               PH_START: begin
                  ev_push        = 1'b1;
                  ev_word.status = set_bad ? ST_BADSET : ST_BADPAT;
               end
               PH_DATA: begin
                  ev_push      = 1'b1;
                  ev_word.kind = EV_FINISH;
               end
               PH_TAIL: begin
                  ev_push = 1'b1;
               end
               default: ev_push = 1'b0;
            endcase
         end else begin
            case (phase_ff)
               PH_START: begin
                  if ((count_ff == 4'd0) && set_bad) begin
                     ev_push        = 1'b1;
                     ev_word.status = ST_BADSET;
                  end else begin
                     window_in = sym_done ? '0 : win_shift;
                     count_in  = sym_done ? '0 : cnt_inc;
                     if (sym_done && !is_start_b) begin
                        ev_push        = 1'b1;
                        ev_word.status = match ? ST_NOSTART : ST_BADPAT;
                     end
                  end
               end
               PH_DATA: begin
                  window_in = sym_done ? '0 : win_shift;
                  count_in  = sym_done ? '0 : cnt_inc;
                  if (sym_done && !is_stop) begin
                     ev_push = 1'b1;
                     if (match) begin
                        ev_word.kind  = EV_DATA;
                        ev_word.value = match_idx;
                     end
                  end
               end
               PH_TAIL: begin
                  window_in = win_shift;
                  count_in  = cnt_inc;
                  if (tail_done) begin
                     ev_push = 1'b1;
                     if (tail_ok) begin
                        ev_word.kind = EV_FINISH;
                     end
                  end
               end
               default: ev_push = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         window_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.func) |=> (phase_ff == PH_START) && (count_ff == 4'd0))
      else $error("end of scan did not clear the collector");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_START) || (phase_ff == PH_DATA)) |-> (count_ff < 4'(SYM_MODULES)))
      else $error("symbol module count overran");

endmodule

// ----- rtl/cbd_back.sv -----
// ----------------------------------------------------------------------------
// Result stage
// Holds back one character and turns events into result words.
// ----------------------------------------------------------------------------
module cbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             ev_empty,
   input  cbd_pkg::ev_type  ev_word,
   output logic             ev_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output cbd_pkg::rsp_type rsp_word
);

   import cbd_pkg::*;

   logic          held_valid_ff, held_valid_in;
   sym_value_type held_value_ff, held_value_in;

   assign ev_pop = !ev_empty && !rsp_full;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      rsp_push      = 1'b0;
      rsp_word      = '{char_out: '0, status: ST_BADPAT, last: 1'b1};
      if (ev_pop) begin
         case (ev_word.kind)
            EV_DATA: begin
               // release the previous character, hold the new one
               rsp_push      = held_valid_ff;
               rsp_word      = '{char_out: {1'b0, held_value_ff} + ASCII_OFFSET,
                                 status: ST_DATA, last: 1'b0};
               held_valid_in = 1'b1;
               held_value_in = ev_word.value;
            end
            EV_FINISH: begin
               rsp_push = 1'b1;
               if (held_valid_ff) begin
                  rsp_word = '{char_out: {1'b0, held_value_ff}, status: ST_CHECK,
                               last: 1'b1};
               end else begin
                  rsp_word = '{char_out: '0, status: ST_EMPTY, last: 1'b1};
               end
               held_valid_in = 1'b0;
               held_value_in = '0;
            end
            EV_ERROR: begin
               rsp_push      = 1'b1;
               rsp_word      = '{char_out: '0, status: ev_word.status, last: 1'b1};
               held_valid_in = 1'b0;
               held_value_in = '0;
            end
            default: rsp_push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_value_ff <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_value_ff <= held_value_in;
      end
   end

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (ev_pop && (ev_word.kind == EV_DATA)) |=> held_valid_ff)
      else $error("data symbol was not held");

   a_drop_on_end: assert property (@(posedge clock) disable iff (reset)
      (ev_pop && (ev_word.kind != EV_DATA)) |=> !held_valid_ff)
      else $error("held character survived end of scan");

endmodule

// ----- rtl/code128b_module_decoder.sv -----
// ----------------------------------------------------------------------------
// Code 128 set B module decoder
// Decodes a stream of barcode module bits into ASCII words.
// ----------------------------------------------------------------------------
// Flow: the edge that accepts an item writes its event into the event queue;
//   the result stage then moves the event into the output queue, from which
//   the rsp ports show it. Throughput: one item per cycle unless the event
//   queue is full; the symbol match compares all 106 patterns combinationally;
//   the result stage retires one event a cycle while the rsp queue has room.
// Reset (synchronous, active high): empties both queues, returns the scan to
//   awaiting Start B and sets the code set register to B.
// ----------------------------------------------------------------------------
module code128b_module_decoder #(
   parameter int EVQ_DEPTH  = 2,
   parameter int RSPQ_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // module stream
   input  logic                  push,
   output logic                  full,
   input  cbd_pkg::req_type      req_data,
   // result stream
   output logic                  empty,
   input  logic                  pop,
   output cbd_pkg::rsp_type      rsp_data,
   // code set register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  cbd_pkg::code_set_type csr_data
);

   import cbd_pkg::*;

   code_set_type code_set_ff, code_set_in;

   // front -> event queue
   logic    ev_push, ev_full;
   ev_type  ev_in_word;
   // event queue -> back
   logic    ev_pop, ev_empty;
   ev_type  ev_out_word;
   // back -> output queue
   logic    rsp_push, rsp_full;
   rsp_type rsp_in_word;

   // Takes a word on any cycle; the user must write only while idle; unenforced.
   assign csr_ready   = 1'b1;
   assign code_set_in = csr_valid ? csr_data : code_set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_set_ff <= CODE_SET_B;
      end else begin
         code_set_ff <= code_set_in;
      end
   end

   // Hold off the stream whenever the event queue cannot take another word,
   // whether or not the next module would finish a symbol.
   assign full = ev_full;

   // Collect modules, match symbols, advance the scan phase.
   cbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_word (req_data),
      .code_set (code_set_ff),
      .ev_full  (ev_full),
      .ev_push  (ev_push),
      .ev_word  (ev_in_word)
   );

   // Decouple classification from result formatting.
   cbd_queue #(
      .WIDTH ($bits(ev_type)),
      .DEPTH (EVQ_DEPTH)
   ) u_ev_queue (
      .clock (clock),
      .reset (reset),
      .push  (ev_push),
      .full  (ev_full),
      .wdata (ev_in_word),
      .pop   (ev_pop),
      .empty (ev_empty),
      .rdata (ev_out_word)
   );

   // Hold back one character, emit data, check, empty and error words.
   cbd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_empty (ev_empty),
      .ev_word  (ev_out_word),
      .ev_pop   (ev_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_word (rsp_in_word)
   );

   // Output queue: the stream keeps moving while a finished word waits.
   cbd_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSPQ_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_in_word),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_data)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code 128 set B module decoder testbench
// Streams barcode modules into the decoder, predicts each result word with a
// local decode model, and checks every popped word field by field. Covers
// good scans, every error path, code set changes and idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import cbd_pkg::*;

   localparam code_set_type  CODE_SET_A    = 2'd0;
   localparam code_set_type  CODE_SET_C    = 2'd2;
   localparam int            START_A_VALUE = 103;
   localparam int            CYCLE_LIMIT   = 500_000;
   localparam int            PHASE_ITEMS   = 350;

   // Idle profiles per random phase: none, sender, receiver, both
   localparam int GAP_PCT [4]   = '{0, 45, 0, 11};
   localparam int STALL_PCT [4] = '{0, 0, 45, 11};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push;
   logic         full;
   req_type      req_data;
   logic         empty;
   logic         pop = 1'b0;
   rsp_type      rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   code_set_type csr_data;

   // Decoder state as the prediction sees it
   code_set_type cs_reg;
   logic [10:0]  sym_window;
   logic [3:0]   sym_count;
   phase_type    scan_state;
   logic         held_ok;
   logic [7:0]   held_char;

   rsp_type pending_words[$];

   int gap_pct   = 0;
   int stall_pct = 0;
   int errors    = 0;
   int cycles    = 0;
   int items_used    = 0;
   int words_checked = 0;
   int scans_sent    = 0;
   int set_writes    = 0;

   code128b_module_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   // Six run widths of a window, one per nibble, oldest run highest; zero when
   // the window does not split into exactly six runs.
   function automatic logic [23:0] run_widths(logic [10:0] w);
      logic [23:0] acc;
      logic [3:0]  run;
      int          nruns;
      acc   = '0;
      run   = 4'd1;
      nruns = 0;
      for (int i = 9; i >= 0; i--) begin
         if (w[i] == w[i + 1]) begin
            run++;
         end else begin
            acc   = {acc[19:0], run};
            nruns++;
            run   = 4'd1;
         end
      end
      acc = {acc[19:0], run};
      nruns++;
      return (nruns == 6) ? acc : '0;
   endfunction

   // Symbol value for a run code, -1 when nothing matches
   function automatic int symbol_value(logic [23:0] code);
      if (code == '0) return -1;
      for (int i = 0; i < SYM_COUNT; i++) begin
         if (SYM_RUNS[i] == code) return i;
      end
      return -1;
   endfunction

   function automatic void queue_word(logic [7:0] ch, status_type st, logic lst);
      rsp_type w;
      w.char_out = ch;
      w.status   = st;
      w.last     = lst;
      pending_words.push_back(w);
   endfunction

   function automatic void clear_scan();
      sym_window = '0;
      sym_count  = '0;
      scan_state = PH_START;
      held_ok    = 1'b0;
      held_char  = '0;
   endfunction

   // Closing word of a scan: the held character as check value, or empty
   function automatic void close_scan();
      if (held_ok) queue_word(held_char, ST_CHECK, 1'b1);
      else queue_word(8'd0, ST_EMPTY, 1'b1);
   endfunction

   // Advance the decode state by one accepted word and queue any result
   function automatic void decode_word(req_type it);
      logic [23:0] code;
      int          val;
      items_used++;
      if (it.func) begin
         case (scan_state)
            PH_START: begin
               queue_word(8'd0, (cs_reg != CODE_SET_B) ? ST_BADSET : ST_BADPAT, 1'b1);
            end
            PH_DATA: close_scan();
            PH_TAIL: queue_word(8'd0, ST_BADPAT, 1'b1);
            default: ;
         endcase
         clear_scan();
         return;
      end
      // modules after a finished scan are dropped
      if (scan_state == PH_DONE) return;
      if (scan_state == PH_START && sym_count == 0 && cs_reg != CODE_SET_B) begin
         scan_state = PH_DONE;
         queue_word(8'd0, ST_BADSET, 1'b1);
         return;
      end
      sym_window = {sym_window[9:0], it.module_bit};
      sym_count++;
      if (scan_state == PH_TAIL) begin
         if (sym_count < 2) return;
         scan_state = PH_DONE;
         // the two tail modules must match
         if (sym_window == 11'd0 || sym_window == 11'd3) close_scan();
         else queue_word(8'd0, ST_BADPAT, 1'b1);
         return;
      end
      if (sym_count < SYM_MODULES) return;
      code       = run_widths(sym_window);
      sym_window = '0;
      sym_count  = '0;
      if (scan_state == PH_START) begin
         val = symbol_value(code);
         if (val < 0) begin
            scan_state = PH_DONE;
            queue_word(8'd0, ST_BADPAT, 1'b1);
         end else if (val != START_B_VALUE) begin
            scan_state = PH_DONE;
            queue_word(8'd0, ST_NOSTART, 1'b1);
         end else begin
            scan_state = PH_DATA;
         end
         return;
      end
      if (code == STOP_HEAD_RUNS) begin
         scan_state = PH_TAIL;
         return;
      end
      val = symbol_value(code);
      if (val < 0) begin
         scan_state = PH_DONE;
         queue_word(8'd0, ST_BADPAT, 1'b1);
         return;
      end
      // release the previous character, hold this one back
      if (held_ok) queue_word(held_char + ASCII_OFFSET, ST_DATA, 1'b0);
      held_ok   = 1'b1;
      held_char = 8'(val);
   endfunction

   // --------------------------------------------------------------------------
   // Result side: random stalls at the falling edge, check at the rising edge
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      pop = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         words_checked++;
         if (pending_words.size() == 0) begin
            $error("unexpected result word: char_out %0d status %0d last %0d",
                   rsp_data.char_out, rsp_data.status, rsp_data.last);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.char_out !== want.char_out) begin
               $error("char_out: expected %0d, actual %0d", want.char_out, rsp_data.char_out);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers; all called at a falling edge and return at one
   // --------------------------------------------------------------------------

   // Offer one word, hold it until taken, then advance the prediction
   task automatic send_word(req_type it);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         push = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      push     = 1'b1;
      req_data = it;
      do @(posedge clock); while (full);
      decode_word(it);
      @(negedge clock);
   endtask

   task automatic send_module(logic b);
      req_type it;
      it.func       = 1'b0;
      it.module_bit = b;
      send_word(it);
   endtask

   task automatic send_end();
      req_type it;
      it.func       = 1'b1;
      it.module_bit = 1'($urandom_range(1));
      scans_sent++;
      send_word(it);
   endtask

   // Send a symbol from its run widths, bar first unless inverted
   task automatic send_runs(logic [23:0] runs, logic inv);
      logic lvl;
      int   w;
      lvl = ~inv;
      for (int k = 5; k >= 0; k--) begin
         w = int'(runs[k * 4 +: 4]);
         repeat (w) send_module(lvl);
         lvl = ~lvl;
      end
   endtask

   task automatic send_symbol(int val, logic inv);
      send_runs(SYM_RUNS[val], inv);
   endtask

   task automatic send_stop(logic inv, logic [1:0] tail);
      send_runs(STOP_HEAD_RUNS, inv);
      send_module(tail[1]);
      send_module(tail[0]);
   endtask

   task automatic send_noise(int n);
      repeat (n) send_module(1'($urandom_range(1)));
   endtask

   // Hold the stream until every predicted word has been popped
   task automatic wait_for_results();
      push = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   // Drain, then let the two-stage pipeline settle on items with no result
   task automatic wait_idle();
      wait_for_results();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_code_set(code_set_type v);
      wait_idle();
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      cs_reg = v;
      set_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   task automatic test_good_scans();
      // start and stop only: empty message
      send_symbol(START_B_VALUE, 1'b0);
      send_stop(1'b0, 2'b11);
      send_end();
      // table extremes in both polarities; pause mid-scan until drained
      send_symbol(START_B_VALUE, 1'b1);
      send_symbol(0, 1'b0);
      send_symbol(SYM_COUNT - 1, 1'b1);
      wait_for_results();
      send_symbol(95, 1'b0);
      send_stop(1'b1, 2'b00);
      send_module(1'b1);   // dropped, scan already finished
      send_end();
      // function and start codes pass as data; partial symbol at end is dropped
      send_symbol(START_B_VALUE, 1'b0);
      send_symbol(START_B_VALUE, 1'b0);
      send_symbol(96, 1'b1);
      send_noise(4);
      send_end();
   endtask

   task automatic test_scan_errors();
      // unequal stop tail
      send_symbol(START_B_VALUE, 1'b0);
      send_symbol(42, 1'b0);
      send_stop(1'b0, 2'b10);
      send_end();
      // scan ends inside the stop tail
      send_symbol(START_B_VALUE, 1'b1);
      send_symbol(7, 1'b1);
      send_runs(STOP_HEAD_RUNS, 1'b1);
      send_module(1'b0);
      send_end();
      // wrong start symbol, trailing modules ignored
      send_symbol(START_A_VALUE, 1'b0);
      send_noise(3);
      send_end();
      // solid bar is no symbol at all
      repeat (SYM_MODULES) send_module(1'b1);
      send_end();
      // bad data symbol drops the held character
      send_symbol(START_B_VALUE, 1'b0);
      send_symbol(17, 1'b0);
      repeat (SYM_MODULES) send_module(1'b0);
      send_end();
      // stop pattern where start belongs
      send_runs(STOP_HEAD_RUNS, 1'b0);
      send_end();
      // end before a full start symbol, then end with no modules at all
      send_noise(5);
      send_end();
      send_end();
   endtask

   task automatic test_code_sets();
      write_code_set(CODE_SET_A);
      send_symbol(START_B_VALUE, 1'b0);
      send_end();
      send_end();
      write_code_set(CODE_SET_C);
      send_end();
      send_symbol(START_B_VALUE, 1'b1);
      send_symbol(33, 1'b0);
      send_end();
      write_code_set(CODE_SET_B);
      send_symbol(START_B_VALUE, 1'b0);
      send_symbol(65, 1'b0);
      send_stop(1'b0, 2'b11);
      send_end();
   endtask

   // One random scan, mostly well formed with random content
   task automatic random_scan();
      int kind;
      int ending;
      kind = $urandom_range(99);
      if (kind < 70) begin
         send_symbol(START_B_VALUE, 1'($urandom_range(1)));
         repeat ($urandom_range(8)) begin
            send_symbol($urandom_range(SYM_COUNT - 1), 1'($urandom_range(1)));
            if ($urandom_range(49) == 0) wait_for_results();
         end
         ending = $urandom_range(9);
         if (ending <= 5) begin
            send_stop(1'($urandom_range(1)), ($urandom_range(1) != 0) ? 2'b11 : 2'b00);
            send_noise($urandom_range(3));
         end else if (ending == 6) begin
            send_stop(1'($urandom_range(1)), ($urandom_range(1) != 0) ? 2'b10 : 2'b01);
         end else if (ending == 8) begin
            send_noise($urandom_range(1, SYM_MODULES - 1));
         end else if (ending == 9) begin
            send_runs(STOP_HEAD_RUNS, 1'($urandom_range(1)));
            send_noise(1);
         end
      end else if (kind < 85) begin
         // broken scan: a random window among good symbols
         send_symbol(START_B_VALUE, 1'($urandom_range(1)));
         repeat ($urandom_range(3))
            send_symbol($urandom_range(SYM_COUNT - 1), 1'($urandom_range(1)));
         send_noise(SYM_MODULES + $urandom_range(5));
      end else if (kind < 95) begin
         send_symbol($urandom_range(SYM_COUNT - 1), 1'($urandom_range(1)));
         send_noise($urandom_range(4));
      end else begin
         send_noise($urandom_range(30));
      end
      send_end();
   endtask

   task automatic test_random_scans();
      int base;
      for (int p = 0; p < 4; p++) begin
         gap_pct   = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         base      = items_used;
         while (items_used - base < PHASE_ITEMS) random_scan();
         // short excursion into an unsupported code set
         write_code_set(($urandom_range(1) != 0) ? CODE_SET_A : CODE_SET_C);
         random_scan();
         write_code_set(CODE_SET_B);
      end
      gap_pct   = 0;
      stall_pct = 0;
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      push      = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = CODE_SET_B;
      cs_reg    = CODE_SET_B;
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_good_scans();
      test_scan_errors();
      test_code_sets();
      test_random_scans();

      wait_idle();
      repeat (4) @(negedge clock);
      $display("Sent %0d module and end-of-scan words over %0d scans, checked %0d results.",
               items_used, scans_sent, words_checked);
      $display("Wrote the code set %0d times across sets A, B and C under four idle profiles.",
               set_writes);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
